[rtl/core/lphs_pkg.sv]
// ============================================================================
// lphs_pkg
// Shared types and constants for the linear probe hash store: the item
// structures on the ports, the stored record and the status codes.
// ============================================================================
`default_nettype none

package lphs_pkg;

  // Field widths fixed by the item format.
  localparam int KEY_W     = 31;
  localparam int NAME_W    = 48;
  localparam int SAL_W     = 31;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 5;
  localparam int CFG_W     = 6;

  // Default table depth and the cap on results in one listing.
  localparam int SLOTS_DEF = 32;
  localparam int MAX_OUT   = 32;
  localparam int CNT_W     = $clog2(MAX_OUT);

  // Reset value of the table size register.
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(32);

  // Function codes of an input item.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LIST   = 1'b1;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LISTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_chars_0_5;
    logic [NAME_W-1:0] name_chars_6_11;
    logic [NAME_W-1:0] name_chars_12_17;
    logic [SAL_W-1:0]  salary;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    out_key;
    logic [NAME_W-1:0]   out_name_0_5;
    logic [NAME_W-1:0]   out_name_6_11;
    logic [NAME_W-1:0]   out_name_12_17;
    logic [SAL_W-1:0]    out_salary;
    logic                last;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_low;
    logic [NAME_W-1:0] name_mid;
    logic [NAME_W-1:0] name_high;
    logic [SAL_W-1:0]  salary;
  } record_t;

endpackage

`default_nettype wire

[rtl/core/lphs_mod.sv]
// ============================================================================
// lphs_mod
// Restoring remainder unit: reduces the key modulo the table size, one
// dividend bit per cycle, and pulses done with the remainder.
// ============================================================================
`default_nettype none

module lphs_mod #(
  parameter int SLOTS = lphs_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lphs_pkg::KEY_W-1:0]     dividend,
  input  logic [$clog2(SLOTS+1)-1:0]     divisor,
  output logic                           done,
  output logic [$clog2(SLOTS+1)-1:0]     rem
);
  import lphs_pkg::*;

  localparam int NW    = $clog2(SLOTS + 1);
  localparam int STEPW = $clog2(KEY_W);

  logic             run_r,  run_nxt;
  logic             done_r, done_nxt;
  logic [STEPW-1:0] step_r, step_nxt;
  logic [KEY_W-1:0] dvd_r,  dvd_nxt;
  logic [NW-1:0]    rem_r,  rem_nxt;
  logic [NW:0]      trial;

  // One restoring step: shift in the next key bit, subtract if it fits.
  always_comb begin
    trial    = {rem_r, dvd_r[KEY_W-1]};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      dvd_nxt  = {dvd_r[KEY_W-2:0], 1'b0};
      step_nxt = step_r + STEPW'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = NW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = NW'(trial);
      end
      if (step_r == STEPW'(KEY_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[rtl/core/lphs_store.sv]
// ============================================================================
// lphs_store
// Record memory with one write and one registered read port, plus the
// occupied marks, which reset clears.
// ============================================================================
`default_nettype none

module lphs_store #(
  parameter int SLOTS = lphs_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  lphs_pkg::record_t          wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr,
  output lphs_pkg::record_t          rd_data,
  output logic [SLOTS-1:0]           occ
);
  import lphs_pkg::*;

  record_t          mem_r [SLOTS];
  record_t          rd_data_r;
  logic [SLOTS-1:0] occ_r;

  // Occupied marks: set on each write, cleared only by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (wr_en) begin
      occ_r[wr_addr] <= 1'b1;
    end
  end

  // Record storage, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign occ     = occ_r;

endmodule

`default_nettype wire

[rtl/core/linear_probe_hash_store_top.sv]
// ============================================================================
// linear_probe_hash_store_top
// Record table with open addressing, a division hash and linear probing.
// ============================================================================
// An item is taken when start is high and busy low; busy then stays high
// until the cycle in which the item's last result is shown, and a new item
// may be taken in that same cycle. An insert starts the remainder unit,
// which reduces the key one key bit a cycle, then loads the home slot and
// probes one slot per cycle. A listing passes one empty slot per cycle, and
// for each listed record first reads the memory and then shows the result,
// since the record memory has a single registered read port. Each result
// is on the out_ ports for one cycle under out_strobe and cannot be held
// off, so the receiver must take it there and then. The table size
// register is written through cfg_we and cfg_wdata; the user must write it
// only while busy is low, which the block itself does not enforce. Values
// outside 1 to SLOTS are clamped. There is no clearing pass: reset clears
// the occupied marks at once.
// ============================================================================
`default_nettype none

module linear_probe_hash_store_top #(
  parameter int SLOTS = lphs_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lphs_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output lphs_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [lphs_pkg::CFG_W-1:0]  cfg_wdata
);
  import lphs_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [CFG_W-1:0] size_r;
  logic [2:0]       state_r,  state_nxt;
  in_item_t         item_r,   item_nxt;
  logic [NW-1:0]    n_r,      n_nxt;
  logic [SW-1:0]    idx_r,    idx_nxt;
  logic [SW-1:0]    home_r,   home_nxt;
  logic [NW-1:0]    scan_r,   scan_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             ostb_r,   ostb_nxt;
  out_item_t        oitem_r,  oitem_nxt;

  logic             accept;
  logic             mod_start;
  logic             mod_done;
  logic [NW-1:0]    mod_rem;
  logic             wr_en;
  logic             rd_en;
  record_t          wr_data;
  record_t          rd_data;
  logic [SLOTS-1:0] occ;
  logic [NW-1:0]    idx_inc;
  logic [SW-1:0]    idx_wrap;
  logic             more;
  logic             is_last;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign mod_start = accept && (in_item.func == FUNC_INSERT);

  // Table size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Effective size, clamped to 1 .. SLOTS.
  always_comb begin
    if (size_r == '0) begin
      n_nxt = NW'(1);
    end else if (32'(size_r) > 32'(SLOTS)) begin
      n_nxt = NW'(SLOTS);
    end else begin
      n_nxt = NW'(size_r);
    end
  end

  lphs_mod #(.SLOTS(SLOTS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_item.key),
    .divisor  (n_nxt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lphs_store #(.SLOTS(SLOTS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_r[SW-1:0]),
    .rd_data (rd_data),
    .occ     (occ)
  );

  // Record to store, in the field order of record_t.
  assign wr_data = {item_r.key, item_r.name_chars_0_5, item_r.name_chars_6_11,
                    item_r.name_chars_12_17, item_r.salary};

  // Next probe slot, wrapping at the effective size.
  assign idx_inc  = NW'(idx_r) + NW'(1);
  assign idx_wrap = (idx_inc == n_r) ? '0 : SW'(idx_inc);

  // Whether any occupied slot lies above the scan position and below the size.
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (occ[j] && (NW'(j) > scan_r) && (NW'(j) < n_r)) begin
        more = 1'b1;
      end
    end
  end

  assign is_last = (cnt_r == CNT_W'(MAX_OUT - 1)) || !more;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    idx_nxt   = idx_r;
    home_nxt  = home_r;
    scan_nxt  = scan_r;
    cnt_nxt   = cnt_r;
    ostb_nxt  = 1'b0;
    oitem_nxt = oitem_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_item;
          scan_nxt = '0;
          cnt_nxt  = '0;
          if (in_item.func == FUNC_INSERT) begin
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          home_nxt  = SW'(mod_rem);
          idx_nxt   = SW'(mod_rem);
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!occ[idx_r]) begin
          // Free slot: store the record here.
          wr_en            = 1'b1;
          ostb_nxt         = 1'b1;
          oitem_nxt        = '0;
          oitem_nxt.status = ST_STORED;
          oitem_nxt.slot   = SLOT_W'(idx_r);
          oitem_nxt.last   = 1'b1;
          state_nxt        = S_IDLE;
        end else if (idx_wrap == home_r) begin
          // Probe came back round to the home slot.
          ostb_nxt         = 1'b1;
          oitem_nxt        = '0;
          oitem_nxt.status = ST_FULL;
          oitem_nxt.slot   = SLOT_W'(home_r);
          oitem_nxt.last   = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          idx_nxt = idx_wrap;
        end
      end
      S_SCAN: begin
        if (scan_r == n_r) begin
          // Only reached when nothing was listed.
          ostb_nxt         = 1'b1;
          oitem_nxt        = '0;
          oitem_nxt.status = ST_EMPTY;
          oitem_nxt.last   = 1'b1;
          state_nxt        = S_IDLE;
        end else if (occ[scan_r[SW-1:0]]) begin
          rd_en     = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          scan_nxt = scan_r + NW'(1);
        end
      end
      S_EMIT: begin
        ostb_nxt                 = 1'b1;
        oitem_nxt.status         = ST_LISTED;
        oitem_nxt.slot           = SLOT_W'(scan_r);
        oitem_nxt.out_key        = rd_data.key;
        oitem_nxt.out_name_0_5   = rd_data.name_low;
        oitem_nxt.out_name_6_11  = rd_data.name_mid;
        oitem_nxt.out_name_12_17 = rd_data.name_high;
        oitem_nxt.out_salary     = rd_data.salary;
        oitem_nxt.last           = is_last;
        if (is_last) begin
          state_nxt = S_IDLE;
        end else begin
          scan_nxt  = scan_r + NW'(1);
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ostb_r  <= ostb_nxt;
    end
    item_r  <= item_nxt;
    n_r     <= (state_r == S_IDLE) ? n_nxt : n_r;
    idx_r   <= idx_nxt;
    home_r  <= home_nxt;
    scan_r  <= scan_nxt;
    cnt_r   <= cnt_nxt;
    oitem_r <= oitem_nxt;
  end

  assign out_strobe = ostb_r;
  assign out_item   = oitem_r;

endmodule

`default_nettype wire

[rtl/core/lphs_checker.sv]
// ============================================================================
// lphs_checker
// Port-level checks on the hash store's command handshake and results,
// bound to the top level.
// ============================================================================
`default_nettype none

module lphs_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 out_strobe,
  input  lphs_pkg::out_item_t  out_item
);
  import lphs_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // A result that is not the last one arrives while the block is still busy.
  a_more_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> busy)
    else $error("non-final result while idle");

  // Store, full and empty reports always close their item.
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_STORED || out_item.status == ST_FULL ||
                    out_item.status == ST_EMPTY)) |-> out_item.last)
    else $error("single result without last");

  // Record fields are zero outside listing results.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_LISTED) |->
      (out_item.out_key == '0 && out_item.out_salary == '0 &&
       out_item.out_name_0_5 == '0))
    else $error("record fields not cleared");

  // After the last result no result follows in the next cycle.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |=> !out_strobe)
    else $error("result straight after the last one");

endmodule

bind linear_probe_hash_store_top lphs_checker u_lphs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire

[dv/tb_linear_probe_hash_store_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_linear_probe_hash_store_top
// Self-checking bench for the linear probe hash store. A driver feeds insert
// and listing items from a queue, and a monitor keeps its own copy of the
// table. The monitor predicts the status, slot and listed records of every
// accepted item and checks each strobed result against the oldest
// prediction. The table size is changed between phases, and the sender's
// idling differs from one phase to the next.
// ============================================================================

module tb_linear_probe_hash_store_top;
  import lphs_pkg::*;

  localparam int NUM_SLOTS      = SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 70;

  // One queued item, with a flag that holds it back until the block has drained.
  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } table_op_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_item_t        in_item = '0;
  logic            out_strobe;
  out_item_t       out_item;
  logic            cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Local copy of the table and its size register.
  logic            occupied[NUM_SLOTS];
  record_t         stored_recs[NUM_SLOTS];
  logic [CFG_W-1:0] table_size_reg = TABLE_SIZE_RST;

  table_op_t       pending_ops[$];
  out_item_t       expected_results[$];
  int              queued_cnt = 0;
  int              taken_cnt = 0;
  int              popped_cnt = 0;
  int              idle_pct = 0;
  int              quiet_cycles = 0;
  int              mismatch_cnt = 0;

  linear_probe_hash_store_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Number of slots in use: the register clamped to 1 .. NUM_SLOTS.
  function automatic int table_slots();
    int n;
    n = int'(table_size_reg);
    if (n < 1) n = 1;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    return n;
  endfunction

  // Works out the results of one accepted item and updates the local table.
  function automatic void predict_table_op(input in_item_t op);
    int n;
    int home;
    int idx;
    int total;
    int done;
    logic [31:0] key32;
    bit full;
    out_item_t res;
    n = table_slots();
    res = '0;
    if (op.func == FUNC_INSERT) begin
      key32 = {1'b0, op.key};
      home = int'(key32 % n);
      idx = home;
      full = 1'b0;
      // Probe linearly with wraparound; coming back home means the table is full.
      while (occupied[idx] && !full) begin
        idx = (idx + 1 == n) ? 0 : idx + 1;
        if (idx == home) full = 1'b1;
      end
      res.last = 1'b1;
      if (full) begin
        res.status = ST_FULL;
        res.slot = SLOT_W'(home);
      end else begin
        occupied[idx] = 1'b1;
        stored_recs[idx].key = op.key;
        stored_recs[idx].name_low = op.name_chars_0_5;
        stored_recs[idx].name_mid = op.name_chars_6_11;
        stored_recs[idx].name_high = op.name_chars_12_17;
        stored_recs[idx].salary = op.salary;
        res.status = ST_STORED;
        res.slot = SLOT_W'(idx);
      end
      expected_results.push_back(res);
    end else begin
      total = 0;
      for (int i = 0; i < n; i++) begin
        if (occupied[i] && total < MAX_OUT) total++;
      end
      if (total == 0) begin
        res.status = ST_EMPTY;
        res.last = 1'b1;
        expected_results.push_back(res);
      end else begin
        done = 0;
        for (int i = 0; i < n && done < total; i++) begin
          if (occupied[i]) begin
            done++;
            res.status = ST_LISTED;
            res.slot = SLOT_W'(i);
            res.out_key = stored_recs[i].key;
            res.out_name_0_5 = stored_recs[i].name_low;
            res.out_name_6_11 = stored_recs[i].name_mid;
            res.out_name_12_17 = stored_recs[i].name_high;
            res.out_salary = stored_recs[i].salary;
            res.last = (done == total);
            expected_results.push_back(res);
          end
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with none pending, status", 64'(got.status), '0);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.slot !== want.slot)
        report_mismatch("slot", 64'(got.slot), 64'(want.slot));
      if (got.out_key !== want.out_key)
        report_mismatch("out_key", 64'(got.out_key), 64'(want.out_key));
      if (got.out_name_0_5 !== want.out_name_0_5)
        report_mismatch("out_name_0_5", 64'(got.out_name_0_5), 64'(want.out_name_0_5));
      if (got.out_name_6_11 !== want.out_name_6_11)
        report_mismatch("out_name_6_11", 64'(got.out_name_6_11), 64'(want.out_name_6_11));
      if (got.out_name_12_17 !== want.out_name_12_17)
        report_mismatch("out_name_12_17", 64'(got.out_name_12_17),
                        64'(want.out_name_12_17));
      if (got.out_salary !== want.out_salary)
        report_mismatch("out_salary", 64'(got.out_salary), 64'(want.out_salary));
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
    end
  endtask

  // A name word that is mostly random, with all-zero and all-one cases mixed in.
  function automatic logic [NAME_W-1:0] random_name_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return NAME_W'({$urandom, $urandom});
  endfunction

  // Fully random item fields; also driven as noise while start is low.
  function automatic in_item_t random_fields();
    in_item_t it;
    it.func = 1'($urandom_range(1));
    it.key = KEY_W'($urandom);
    it.name_chars_0_5 = NAME_W'({$urandom, $urandom});
    it.name_chars_6_11 = NAME_W'({$urandom, $urandom});
    it.name_chars_12_17 = NAME_W'({$urandom, $urandom});
    it.salary = SAL_W'($urandom);
    return it;
  endfunction

  // A random insert or listing, with keys aimed at collisions and extremes.
  function automatic in_item_t random_table_op(input int insert_pct);
    in_item_t it;
    int sel;
    it = random_fields();
    it.func = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_LIST;
    sel = $urandom_range(99);
    if (sel < 40) it.key = KEY_W'($urandom);
    else if (sel < 65) it.key = KEY_W'($urandom_range(63));
    else if (sel < 80) it.key = KEY_W'($urandom_range(1000) * table_slots() + $urandom_range(3));
    else if (sel < 90) it.key = {KEY_W{1'b1}} - KEY_W'($urandom_range(40));
    else it.key = $urandom_range(1) ? '1 : '0;
    it.name_chars_0_5 = random_name_word();
    it.name_chars_6_11 = random_name_word();
    it.name_chars_12_17 = random_name_word();
    sel = $urandom_range(99);
    if (sel < 10) it.salary = '0;
    else if (sel < 20) it.salary = '1;
    return it;
  endfunction

  task automatic queue_op(input in_item_t it, input bit wait_drain);
    table_op_t op;
    op.item = it;
    op.wait_drain = wait_drain;
    pending_ops.push_back(op);
    queued_cnt++;
  endtask

  task automatic queue_insert(input logic [KEY_W-1:0] key, input logic [NAME_W-1:0] name,
                              input logic [SAL_W-1:0] salary);
    in_item_t it;
    it.func = FUNC_INSERT;
    it.key = key;
    it.name_chars_0_5 = name;
    it.name_chars_6_11 = ~name;
    it.name_chars_12_17 = NAME_W'({$urandom, $urandom});
    it.salary = salary;
    queue_op(it, 1'b0);
  endtask

  task automatic queue_listing();
    in_item_t it;
    it = random_fields();
    it.func = FUNC_LIST;
    queue_op(it, 1'b0);
  endtask

  // Waits until every queued item is taken, every result has come and busy is low.
  task automatic wait_drained();
    do @(negedge clk);
    while (taken_cnt != queued_cnt || expected_results.size() != 0 || busy);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: holds an item on the port until it is taken, then moves on.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else if (popped_cnt != taken_cnt || !start) begin
      if (popped_cnt != taken_cnt) begin
        pending_ops.delete(0);
        popped_cnt = taken_cnt;
      end
      if (pending_ops.size() != 0 &&
          !(pending_ops[0].wait_drain && (expected_results.size() != 0 || busy)) &&
          $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_item <= pending_ops[0].item;
      end else begin
        start <= 1'b0;
        in_item <= random_fields();
      end
    end
  end

  // Monitor: tracks register writes, checks results and predicts taken items.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        occupied[i] = 1'b0;
        stored_recs[i] = '0;
      end
      table_size_reg = TABLE_SIZE_RST;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) table_size_reg = cfg_wdata;
      if (out_strobe) check_result(out_item);
      if (start && !busy) begin
        predict_table_op(in_item);
        taken_cnt++;
      end
      // Watchdog on cycles in which neither side moves an item.
      if (out_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus: a directed opening, then random phases with different sizes and idling.
  initial begin
    int phase_size[6] = '{6, 12, 20, 9, 33, 32};
    int phase_idle[6] = '{0, 85, 0, 21, 0, 85};
    int phase_insert[6] = '{80, 80, 75, 70, 75, 60};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Empty listing, then extreme keys, a collision, a wrapping probe and a repeated key.
    queue_listing();
    queue_insert('0, '0, '0);
    queue_insert('1, '1, '1);
    queue_insert(KEY_W'(32), 48'h0102_0304_0506, 31'h1234_5678);
    queue_insert(KEY_W'(63), 48'hA5A5_5A5A_C3C3, 31'h0000_0001);
    queue_insert('0, 48'h8000_0000_0001, 31'h4000_0000);
    queue_listing();

    // Size 0 acts as 1: the home slot is taken, and the upper records stay hidden.
    write_table_size('0);
    queue_insert(KEY_W'(5), 48'h1111_2222_3333, 31'h0000_0055);
    queue_listing();
    write_table_size(CFG_W'(1));
    queue_insert('1, '1, '0);
    // Two slots, both in use: the probe wraps back to its home slot.
    write_table_size(CFG_W'(2));
    queue_insert(KEY_W'(7), 48'h7777_7777_7777, 31'h0000_0777);
    queue_listing();
    // Values above the slot count are clamped to the full table.
    write_table_size('1);
    queue_insert(KEY_W'(30), 48'hFEDC_BA98_7654, 31'h7FFF_FFFE);
    queue_listing();

    for (int p = 0; p < 6; p++) begin
      write_table_size(CFG_W'(phase_size[p]));
      idle_pct = phase_idle[p];
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_op(random_table_op(phase_insert[p]), i == 35 || $urandom_range(99) < 3);
    end

    wait_drained();
    repeat (80) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'(expected_results.size()), '0);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
